/* rtl/mrad_pkg.sv */
package mrad_pkg;

  // Request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_XLATE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNMAPPED  = 3'd4,
    ST_BAD_RANGE = 3'd5,
    ST_READ_ONLY = 3'd6
  } mrad_status_e;

  // 4 GiB boundary at the widths used for sizes and for sums
  localparam logic [32:0] SIZE_LIMIT = 33'h1_0000_0000;
  localparam logic [33:0] SUM_LIMIT  = 34'h1_0000_0000;

  // One region table entry
  typedef struct packed {
    logic [31:0] base;
    logic [32:0] size;
    logic [32:0] span;
    logic [31:0] fold_mask;
    logic        read_only;
  } mrad_entry_t;

endpackage

/* rtl/mrad_if.sv */
interface mrad_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [32:0] address;
  logic [32:0] size_value;
  logic [31:0] mirror_span;
  logic        read_only;
  logic        is_write;

  modport source (
    output valid, req_type, address, size_value, mirror_span, read_only, is_write,
    input  ready
  );
  modport sink (
    input  valid, req_type, address, size_value, mirror_span, read_only, is_write,
    output ready
  );
endinterface

interface mrad_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  region_index;
  logic [31:0] store_offset;

  modport source (
    output valid, status, region_index, store_offset,
    input  ready
  );
  modport sink (
    input  valid, status, region_index, store_offset,
    output ready
  );
endinterface

/* rtl/mirrored_region_address_decoder_unit.sv */
// Mirrored region address decoder.
// Request channel req_i (valid/ready) carries either an add-region item or a
// translate item; response channel rsp_o returns exactly one item per request:
// status, slot index and store offset (index and offset are zero on error).
// Sequence per item: setup, check, then a walk over the stored regions for the
// overlap scan (add) or the first-match lookup (translate), then two tail
// steps (translate) or one write step (add), then the load into the output
// register. The walk ends early at the first overlap or address match; a
// request rejected by the up-front checks skips the walk and goes straight
// to the output register. A single comparator walks the table memory one
// entry a cycle. One item is in flight at a time: req_i.ready is high only
// while the sequencer is idle, so a new request is accepted only once the
// previous item has left the sequencer.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits; a stalled receiver only holds the
// sequencer in its final step until the output register frees up.
// Reset empties the table (the entry count goes to zero) and drops any
// pending response; table memory contents are not cleared, only entries below
// the count are ever read.
module mirrored_region_address_decoder_unit #(
  parameter int MAX_REGIONS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  mrad_req_if.sink  req_i,
  mrad_rsp_if.source rsp_o
);
  import mrad_pkg::*;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_TAIL1 = 3'd4;
  localparam logic [2:0] S_TAIL2 = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // latched request
  logic        type_q, ro_q, wr_q;
  logic [32:0] addr_q, len_q;
  logic [31:0] dspan_q;

  // working registers
  logic [32:0]      span_q, span_d;
  logic [33:0]      sum_q, sum_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  mrad_entry_t      hit_q, hit_d;
  logic [31:0]      off_q, off_d;
  logic [31:0]      boff_q, boff_d;
  logic             f1_q, f1_d;
  mrad_status_e     res_st_q, res_st_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic [31:0]      res_off_q, res_off_d;

  // output register
  mrad_status_e out_st_q;
  logic [3:0]   out_idx_q;
  logic [31:0]  out_off_q;
  logic         out_load;

  // table memory
  mrad_entry_t      mem [MAX_REGIONS];
  mrad_entry_t      rd_q;
  logic [IDX_W-1:0] ra;
  logic             mem_we;
  mrad_entry_t      wd;

  logic accept;
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // shared compare unit: position of the request address against one entry
  logic [32:0] diff;
  logic        below, in_span, end_hit, last;
  assign diff    = {1'b0, addr_q[31:0]} - {1'b0, rd_q.base};
  assign below   = diff[32];
  assign in_span = !below && ({1'b0, diff[31:0]} < rd_q.span);
  assign end_hit = {2'b00, rd_q.base} < sum_q;
  assign last    = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;

  // request validity
  logic [32:0] size_m1;
  logic        add_bad, xl_bad;
  assign size_m1 = len_q - 33'd1;
  assign add_bad = addr_q[32] || (len_q == '0) || (len_q > SIZE_LIMIT) ||
                   (span_q < len_q) || (sum_q > SUM_LIMIT) ||
                   ((span_q != len_q) &&
                    (((len_q & size_m1) != '0) || ((span_q & size_m1) != '0)));
  assign xl_bad  = (len_q == '0) || addr_q[32] || (sum_q > SUM_LIMIT);

  logic [32:0] span_sel;
  assign span_sel = (dspan_q == '0) ? len_q : {1'b0, dspan_q};

  always_comb begin
    wd.base      = addr_q[31:0];
    wd.size      = len_q;
    wd.span      = span_q;
    wd.fold_mask = (span_q == len_q) ? '1 : size_m1[31:0];
    wd.read_only = ro_q;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    span_d    = span_q;
    sum_d     = sum_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    off_d     = off_q;
    boff_d    = boff_q;
    f1_d      = f1_q;
    res_st_d  = res_st_q;
    res_idx_d = res_idx_q;
    res_off_d = res_off_q;
    ra        = '0;
    mem_we    = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SETUP;
      end
      S_SETUP: begin
        span_d  = span_sel;
        sum_d   = {1'b0, addr_q} + {1'b0, (type_q == REQ_XLATE) ? len_q : span_sel};
        state_d = S_CHECK;
      end
      S_CHECK: begin
        idx_d     = '0;
        res_idx_d = '0;
        res_off_d = '0;
        if (type_q == REQ_ADD) begin
          if (add_bad) begin
            res_st_d = ST_INVALID;
            state_d  = S_DONE;
          end else if (cnt_q == '0) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_WALK;
          end
        end else begin
          if (xl_bad) begin
            res_st_d = ST_BAD_RANGE;
            state_d  = S_DONE;
          end else if (cnt_q == '0) begin
            res_st_d = ST_UNMAPPED;
            state_d  = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        ra    = last ? '0 : idx_q + IDX_W'(1);
        idx_d = idx_q + IDX_W'(1);
        if (type_q == REQ_ADD) begin
          if ((below || in_span) && end_hit) begin
            res_st_d = ST_OVERLAP;
            state_d  = S_DONE;
          end else if (last) begin
            state_d = S_WRITE;
          end
        end else begin
          if (in_span) begin
            if (wr_q && rd_q.read_only) begin
              res_st_d = ST_READ_ONLY;
              state_d  = S_DONE;
            end else begin
              hit_d     = rd_q;
              off_d     = diff[31:0];
              res_idx_d = idx_q;
              state_d   = S_TAIL1;
            end
          end else if (last) begin
            res_st_d = ST_UNMAPPED;
            state_d  = S_DONE;
          end
        end
      end
      S_TAIL1: begin
        boff_d  = off_q & hit_q.fold_mask;
        f1_d    = len_q > (hit_q.span - {1'b0, off_q});
        state_d = S_TAIL2;
      end
      S_TAIL2: begin
        if (f1_q || ({1'b0, boff_q} > hit_q.size) ||
            (len_q > (hit_q.size - {1'b0, boff_q}))) begin
          res_st_d  = ST_BAD_RANGE;
          res_idx_d = '0;
        end else begin
          res_st_d  = ST_OK;
          res_off_d = boff_q;
        end
        state_d = S_DONE;
      end
      S_WRITE: begin
        if (cnt_q == CNT_W'(MAX_REGIONS)) begin
          res_st_d = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          res_st_d  = ST_OK;
          res_idx_d = cnt_q[IDX_W-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  logic [IDX_W+3:0] idx_ext;
  assign idx_ext = {4'b0000, res_idx_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q  <= req_i.req_type;
      addr_q  <= req_i.address;
      len_q   <= req_i.size_value;
      dspan_q <= req_i.mirror_span;
      ro_q    <= req_i.read_only;
      wr_q    <= req_i.is_write;
    end
    span_q    <= span_d;
    sum_q     <= sum_d;
    idx_q     <= idx_d;
    hit_q     <= hit_d;
    off_q     <= off_d;
    boff_q    <= boff_d;
    f1_q      <= f1_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    res_off_q <= res_off_d;
    if (out_load) begin
      out_st_q  <= res_st_q;
      out_idx_q <= idx_ext[3:0];
      out_off_q <= res_off_q;
    end
  end

  // region table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cnt_q[IDX_W-1:0]] <= wd;
    rd_q <= mem[ra];
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.region_index = out_idx_q;
  assign rsp_o.store_offset = out_off_q;

endmodule

/* rtl/mrad_checker.sv */
module mrad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [3:0]  rsp_index_i,
  input logic [31:0] rsp_offset_i
);
  import mrad_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_index_i) &&
      $stable(rsp_offset_i))
    else $error("response changed while stalled");

  // one item in flight: not ready right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // errors carry zero index and offset
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |->
      (rsp_index_i == 4'd0) && (rsp_offset_i == 32'd0))
    else $error("error result with nonzero index or offset");

endmodule

bind mirrored_region_address_decoder_unit mrad_checker u_mrad_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_index_i  (rsp_o.region_index),
  .rsp_offset_i (rsp_o.store_offset)
);

/* verif/mirrored_region_address_decoder_unit_test.sv */
module mirrored_region_address_decoder_unit_test;
  import mrad_pkg::*;

  localparam int MAX_REGIONS = 16;

  // Two copies of the region table: one shadows the stimulus as it is built,
  // the other follows the items that the block actually accepts.
  localparam int GEN_SIDE = 0;
  localparam int CHK_SIDE = 1;

  localparam logic [63:0] FOUR_GIB = 64'h1_0000_0000;
  localparam logic [63:0] MASK32   = 64'hFFFF_FFFF;

  localparam int RANDOM_ITEMS  = 930;
  localparam int PRESSURE_AT   = 300;   // result count at which the long hold starts
  localparam int PRESSURE_HOLD = 400;
  localparam int IDLE_LIMIT    = 3000;  // cycles without any handshake
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic        req_type;
    logic [32:0] address;
    logic [32:0] size_value;
    logic [31:0] mirror_span;
    logic        read_only;
    logic        is_write;
  } mrad_req_t;

  typedef struct packed {
    mrad_status_e status;
    logic [3:0]   region_index;
    logic [31:0]  store_offset;
  } mrad_rsp_t;

  logic clk_i;
  logic rst_ni;

  mrad_req_if req_if ();
  mrad_rsp_if rsp_if ();

  mirrored_region_address_decoder_unit #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Region tables, indexed by side then slot
  logic [31:0] map_base [2][MAX_REGIONS];
  logic [32:0] map_size [2][MAX_REGIONS];
  logic [32:0] map_span [2][MAX_REGIONS];
  logic [31:0] map_wrap [2][MAX_REGIONS];
  logic        map_ro   [2][MAX_REGIONS];
  int          map_count [2];

  mrad_req_t pending_req_q [$];
  mrad_rsp_t expected_rsp_q [$];
  mrad_req_t cur_req;

  int mismatch_count = 0;
  int reqs_sent      = 0;
  int results_seen   = 0;
  int send_wait      = 0;
  int stall_left     = 0;
  int idle_cycles    = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Decode one request against one side's table; an add that succeeds
  // appends to that table.
  function automatic mrad_rsp_t decode_request(input int side, input mrad_req_t it);
    mrad_rsp_t   r;
    logic [63:0] a, len, sp, rb, off, boff, sz_i, sp_i;
    int          n, hit;
    bit          found;
    r.status        = ST_OK;
    r.region_index  = '0;
    r.store_offset  = '0;
    a     = 64'(it.address);
    len   = 64'(it.size_value);
    n     = map_count[side];
    hit   = 0;
    found = 1'b0;
    if (it.req_type == REQ_ADD) begin
      sp = (it.mirror_span != '0) ? 64'(it.mirror_span) : len;
      if (a > MASK32 || len == 0 || len > FOUR_GIB) begin
        r.status = ST_INVALID;
      end else if (sp < len || a + sp > FOUR_GIB || (sp % len) != 0 ||
                   (sp != len && (len & (len - 1)) != 0)) begin
        // mirrored regions need a power-of-two backing
        r.status = ST_INVALID;
      end else begin
        for (int i = 0; i < n; i++) begin
          rb = 64'(map_base[side][i]);
          if (a < rb + 64'(map_span[side][i]) && rb < a + sp) found = 1'b1;
        end
        if (found) begin
          r.status = ST_OVERLAP;
        end else if (n >= MAX_REGIONS) begin
          r.status = ST_FULL;
        end else begin
          map_base[side][n] = a[31:0];
          map_size[side][n] = len[32:0];
          map_span[side][n] = sp[32:0];
          map_wrap[side][n] = (sp == len) ? 32'hFFFF_FFFF : 32'(len - 1);
          map_ro[side][n]   = it.read_only;
          map_count[side]   = n + 1;
          r.region_index    = 4'(n);
        end
      end
    end else begin
      if (len == 0 || a > MASK32 || len > FOUR_GIB - a) begin
        r.status = ST_BAD_RANGE;
      end else begin
        // first match wins
        for (int i = 0; i < n; i++) begin
          rb = 64'(map_base[side][i]);
          if (!found && a >= rb && a - rb < 64'(map_span[side][i])) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (!found) begin
          r.status = ST_UNMAPPED;
        end else if (it.is_write && map_ro[side][hit]) begin
          r.status = ST_READ_ONLY;
        end else begin
          sz_i = 64'(map_size[side][hit]);
          sp_i = 64'(map_span[side][hit]);
          off  = a - 64'(map_base[side][hit]);
          boff = off & 64'(map_wrap[side][hit]);
          if (len > sp_i - off || boff > sz_i || len > sz_i - boff) begin
            r.status = ST_BAD_RANGE;
          end else begin
            r.region_index = 4'(hit);
            r.store_offset = boff[31:0];
          end
        end
      end
    end
    return r;
  endfunction

  function automatic mrad_req_t make_req(input logic kind, input logic [32:0] addr,
                                         input logic [32:0] size, input logic [31:0] span,
                                         input logic ro, input logic wr);
    mrad_req_t r;
    r.req_type    = kind;
    r.address     = addr;
    r.size_value  = size;
    r.mirror_span = span;
    r.read_only   = ro;
    r.is_write    = wr;
    return r;
  endfunction

  // Queue an item and keep the build-time table in step with it
  task automatic queue_req(input mrad_req_t r);
    mrad_rsp_t unused;
    pending_req_q.push_back(r);
    unused = decode_request(GEN_SIDE, r);
  endtask

  // Per-item wait: mode 0 none, mode 1 uniform 0..16, mode 2 occasional bursts
  function automatic int draw_wait(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  function automatic logic [32:0] rand33();
    return {1'($urandom_range(0, 1)), 32'($urandom())};
  endfunction

  // Well-formed add: power-of-two backing with a mirror factor and an aligned
  // base, or an unmirrored region of arbitrary size.
  function automatic mrad_req_t gen_add();
    logic [63:0] sz, sp, b;
    int          k, m;
    if ($urandom_range(0, 3) != 0) begin
      k  = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 32) : $urandom_range(0, 20);
      m  = $urandom_range(0, 3);
      sz = 64'd1 << k;
      sp = sz << m;
      if (sp > FOUR_GIB) sp = sz;
      b  = 64'($urandom()) & ~(sp - 1);
    end else begin
      sz = 64'($urandom_range(1, 1 << 20));
      sp = sz;
      b  = 64'($urandom()) % (FOUR_GIB - sz + 1);
    end
    return make_req(REQ_ADD, b[32:0], sz[32:0],
                    (sp == sz && ($urandom_range(0, 1) == 0 || sp == FOUR_GIB)) ? 32'd0
                                                                               : sp[31:0],
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Translate aimed at a stored region, with offsets and lengths near the
  // span and backing edges.
  function automatic mrad_req_t gen_xlate();
    logic [63:0] sz, sp, off, boff, len;
    int          i;
    i  = $urandom_range(0, map_count[GEN_SIDE] - 1);
    sz = 64'(map_size[GEN_SIDE][i]);
    sp = 64'(map_span[GEN_SIDE][i]);
    case ($urandom_range(0, 3))
      0:       off = 0;
      1:       off = sp - 1;
      2:       off = ({32'($urandom()), 32'($urandom())}) % sp;
      default: off = ((sp / sz > 1) ? sz * $urandom_range(1, 3) : 0) % sp
                     + (sz - 1) - ((sz - 1) % 64'($urandom_range(1, 8)));
    endcase
    off  = off % sp;
    boff = off & 64'(map_wrap[GEN_SIDE][i]);
    case ($urandom_range(0, 4))
      0:       len = 1;
      1:       len = $urandom_range(1, 16);
      2:       len = sz - boff;
      3:       len = sz - boff + 1;
      default: len = ({32'($urandom()), 32'($urandom())}) % (sz + 1);
    endcase
    return make_req(REQ_XLATE, 33'(64'(map_base[GEN_SIDE][i]) + off), len[32:0],
                    32'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic mrad_req_t gen_noise();
    logic [32:0] sz;
    case ($urandom_range(0, 2))
      0:       sz = rand33();
      1:       sz = 33'($urandom());
      default: sz = 33'($urandom_range(0, 4096));
    endcase
    return make_req(1'($urandom_range(0, 1)), rand33(), sz, 32'($urandom()),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Stimulus build, reset and end-of-run check
  initial begin
    mrad_req_t r;
    int        pick;
    int        total_items;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_ADD;
    req_if.address     = '0;
    req_if.size_value  = '0;
    req_if.mirror_span = '0;
    req_if.read_only   = 1'b0;
    req_if.is_write    = 1'b0;
    rsp_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    map_count[GEN_SIDE] = 0;
    map_count[CHK_SIDE] = 0;

    // Directed: empty table, each invalid-add reason, mirrored and plain
    // regions at both ends of the address space, then lookups at the edges.
    queue_req(make_req(REQ_XLATE, 33'h0, 33'h1, 32'h0, 1'b0, 1'b0));          // empty table
    queue_req(make_req(REQ_XLATE, 33'h10, 33'h0, 32'h0, 1'b0, 1'b0));         // zero length
    queue_req(make_req(REQ_ADD, 33'h1_0000_0000, 33'h100, 32'h0, 1'b0, 1'b0)); // base > 32 bits
    queue_req(make_req(REQ_ADD, 33'h1000, 33'h0, 32'h0, 1'b0, 1'b0));         // zero size
    queue_req(make_req(REQ_ADD, 33'h0, 33'h1_0000_0001, 32'h0, 1'b0, 1'b0));  // size > 4 GiB
    queue_req(make_req(REQ_ADD, 33'h1000, 33'h100, 32'h80, 1'b0, 1'b0));      // span < size
    queue_req(make_req(REQ_ADD, 33'hFFFF_FF00, 33'h200, 32'h0, 1'b0, 1'b0));  // past 4 GiB
    queue_req(make_req(REQ_ADD, 33'h1000, 33'h100, 32'h180, 1'b0, 1'b0));     // not a multiple
    queue_req(make_req(REQ_ADD, 33'h1000, 33'h300, 32'h600, 1'b0, 1'b0));     // mirror, not pow2
    queue_req(make_req(REQ_ADD, 33'h0, 33'h1000, 32'h4000, 1'b0, 1'b1));      // slot 0, 4 copies
    queue_req(make_req(REQ_ADD, 33'hFFFF_0000, 33'h1_0000, 32'h0, 1'b1, 1'b0)); // slot 1, ROM top
    queue_req(make_req(REQ_ADD, 33'h3000, 33'h1000, 32'h0, 1'b0, 1'b0));      // overlaps slot 0
    queue_req(make_req(REQ_ADD, 33'h1_0000, 33'h3000, 32'h3000, 1'b0, 1'b0)); // plain, odd size
    queue_req(make_req(REQ_ADD, 33'h0, 33'h1_0000_0000, 32'h0, 1'b0, 1'b0));  // whole space
    queue_req(make_req(REQ_XLATE, 33'h2010, 33'h10, 32'h0, 1'b0, 1'b1));      // mirror copy
    queue_req(make_req(REQ_XLATE, 33'hFFFF_FFFF, 33'h1, 32'h0, 1'b0, 1'b1));  // write to ROM
    queue_req(make_req(REQ_XLATE, 33'hFFFF_FFFF, 33'h1, 32'hFFFF_FFFF, 1'b1, 1'b0)); // last byte
    queue_req(make_req(REQ_XLATE, 33'hFFFF_FFFF, 33'h2, 32'h0, 1'b0, 1'b0));  // past 4 GiB
    queue_req(make_req(REQ_XLATE, 33'h1_0000_0000, 33'h1, 32'h0, 1'b0, 1'b0)); // addr > 32 bits
    queue_req(make_req(REQ_XLATE, 33'h0FF8, 33'h10, 32'h0, 1'b0, 1'b0));      // crosses backing
    queue_req(make_req(REQ_XLATE, 33'h3FF8, 33'h10, 32'h0, 1'b0, 1'b0));      // crosses span
    queue_req(make_req(REQ_XLATE, 33'h5000, 33'h4, 32'h0, 1'b0, 1'b0));       // hole
    queue_req(make_req(REQ_XLATE, 33'h0, 33'h1_0000_0000, 32'h0, 1'b0, 1'b0)); // full length
    queue_req(make_req(REQ_XLATE, 33'h12FFF, 33'h1, 32'h0, 1'b0, 1'b1));      // odd-size end
    queue_req(make_req(REQ_XLATE, 33'h0, 33'h1_FFFF_FFFF, 32'h0, 1'b0, 1'b0)); // max length

    // Random: fill the table early, then mostly aimed translates
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        r = gen_noise();
      end else if (pick < ((map_count[GEN_SIDE] < MAX_REGIONS) ? 60 : 35)) begin
        r = gen_add();
      end else if (map_count[GEN_SIDE] > 0) begin
        r = gen_xlate();
      end else begin
        r = gen_noise();
      end
      queue_req(r);
    end
    total_items = pending_req_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // every queued item answers once; the watchdog covers a lost one
    while (results_seen < total_items)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Request driver: one item per handshake, a drawn gap after each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_ADD;
      req_if.address     <= '0;
      req_if.size_value  <= '0;
      req_if.mirror_span <= '0;
      req_if.read_only   <= 1'b0;
      req_if.is_write    <= 1'b0;
      send_wait           = 0;
      map_count[CHK_SIDE] = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsp_q.push_back(decode_request(CHK_SIDE, cur_req));
        reqs_sent++;
      end
      // Channel is free unless an item is still being offered
      if (!req_if.valid || req_if.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          req_if.valid <= 1'b0;
        end else if (pending_req_q.size() != 0) begin
          cur_req             = pending_req_q.pop_front();
          req_if.valid       <= 1'b1;
          req_if.req_type    <= cur_req.req_type;
          req_if.address     <= cur_req.address;
          req_if.size_value  <= cur_req.size_value;
          req_if.mirror_span <= cur_req.mirror_span;
          req_if.read_only   <= cur_req.read_only;
          req_if.is_write    <= cur_req.is_write;
          send_wait           = draw_wait((reqs_sent / 40) % 3);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each item against the oldest expectation and
  // stalls for a drawn number of cycles after it; once a long hold lets the
  // output register and then the request side back up.
  always @(posedge clk_i or negedge rst_ni) begin
    mrad_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left    = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d index %0d offset %h", $time,
                   rsp_if.status, rsp_if.region_index, rsp_if.store_offset);
          mismatch_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (exp_rsp.status !== rsp_if.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time,
                     exp_rsp.status, rsp_if.status);
            mismatch_count++;
          end
          if (exp_rsp.region_index !== rsp_if.region_index) begin
            $display("%0t: region_index mismatch, expected %0d, got %0d", $time,
                     exp_rsp.region_index, rsp_if.region_index);
            mismatch_count++;
          end
          if (exp_rsp.store_offset !== rsp_if.store_offset) begin
            $display("%0t: store_offset mismatch, expected %h, got %h", $time,
                     exp_rsp.store_offset, rsp_if.store_offset);
            mismatch_count++;
          end
        end
        results_seen++;
        stall_left = (results_seen == PRESSURE_AT) ? PRESSURE_HOLD
                                                   : draw_wait((results_seen / 40 + 1) % 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a handshake on either side ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
rtl/mrad_pkg.sv
rtl/mrad_if.sv
rtl/mirrored_region_address_decoder_unit.sv
rtl/mrad_checker.sv
verif/mirrored_region_address_decoder_unit_test.sv
